>>> rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared assertion macros for the lossless audio Golomb encoder RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must never hold outside reset
`define LAGC_ASSERT_NEVER(name, clk, rst_n, expr) \
  name: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("forbidden condition observed");

// Antecedent implies consequent in the same cycle
`define LAGC_ASSERT_IMPLIES(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication violated");

`endif

>>> rtl/lagc_pkg.sv
// ----------------------------------------------------------------------------
// lagc_pkg
// Shared widths, constants, codes and types of the lossless audio encoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lagc_pkg;

  // Sizing
  localparam int MAX_CHANNELS = 8;
  localparam int HISTORY_TAPS = 3;
  localparam int QUEUE_DEPTH  = 4;

  // Field widths
  localparam int SAMPLE_W   = 16;
  localparam int ORDER_W    = 2;
  localparam int M_W        = 16;
  localparam int COUNT_W    = 4;
  localparam int MAPPED_W   = SAMPLE_W + 1;
  localparam int ZRUN_W     = 14;
  localparam int SUFFIX_W   = 16;
  localparam int SLEN_W     = 5;
  localparam int CODED_CH_W = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // Arithmetic limits
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX   = 16'sh7FFF;
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN   = 16'sh8000;
  localparam logic [ZRUN_W-1:0]          QUOTIENT_CAP = 14'd10000;

  // Register reset values
  localparam logic [ORDER_W-1:0] ORDER_RST = 2'd0;
  localparam logic [M_W-1:0]     M_RST     = 16'd4;
  localparam logic [COUNT_W-1:0] COUNT_RST = 4'd2;

  // Register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ORDER    = 2'd0,
    CFG_GOLOMB_M = 2'd1,
    CFG_CHANNELS = 2'd2
  } cfg_idx_e;

  // Predictor orders
  typedef enum logic [ORDER_W-1:0] {
    ORD_NONE  = 2'd0,
    ORD_ONE   = 2'd1,
    ORD_TWO   = 2'd2,
    ORD_THREE = 2'd3
  } order_e;

  // Front-end sequencer
  typedef enum logic [1:0] {
    F_IDLE,
    F_READ,
    F_PRED,
    F_PUSH
  } front_state_e;

  // Back-end coder
  typedef enum logic [1:0] {
    B_IDLE,
    B_DIV,
    B_DONE
  } back_state_e;

  // One residual waiting to be coded
  typedef struct packed {
    logic [MAPPED_W-1:0]   mapped;
    logic [CODED_CH_W-1:0] ch;
    logic                  last;
  } job_t;

endpackage

>>> rtl/lagc_front.sv
// ----------------------------------------------------------------------------
// lagc_front
// Accepts samples, forms mid/side pairs when two channels are set, predicts
// from per-channel history and queues folded residuals for the coder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lagc_front import lagc_pkg::*; #(
  parameter int MaxChannels = MAX_CHANNELS
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [ORDER_W-1:0]         predictor_order_i,
  input  logic [COUNT_W-1:0]         channel_count_i,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic signed [SAMPLE_W-1:0] sample_i,
  output logic                       push_o,
  output job_t                       job_o,
  input  logic                       full_i
);

  localparam int CH_W   = (MaxChannels > 1) ? $clog2(MaxChannels) : 1;
  localparam int N_W    = COUNT_W + 1;
  localparam int ROW_W  = HISTORY_TAPS * SAMPLE_W;
  localparam int PRED_W = SAMPLE_W + 3;
  localparam int RES_W  = SAMPLE_W + 1;

  localparam logic signed [PRED_W-1:0] PMAX = PRED_W'(SAMPLE_MAX);
  localparam logic signed [PRED_W-1:0] PMIN = PRED_W'(SAMPLE_MIN);

  front_state_e state_q, state_d;

  logic [CH_W-1:0]            pos_q, pos_d;
  logic signed [SAMPLE_W-1:0] held_q, held_d;
  logic [CH_W-1:0]            cur_ch_q, cur_ch_d;
  logic signed [SAMPLE_W-1:0] cur_smp_q, cur_smp_d;
  logic                       cur_last_q, cur_last_d;
  logic                       pend_q, pend_d;
  logic signed [SAMPLE_W-1:0] pend_smp_q, pend_smp_d;
  logic signed [SAMPLE_W-1:0] pred_q, pred_d;

  logic [ROW_W-1:0]       hist_mem [MaxChannels];
  logic [ROW_W-1:0]       rd_row_q;
  logic                   rd_vld_q;
  logic [MaxChannels-1:0] row_vld_q;

  logic                       accept, start, rd_en;
  logic [N_W-1:0]             eff_n, pos_x, pos_eff, pos_inc, pos_next;
  logic                       stereo;
  logic signed [SAMPLE_W-1:0] side, half, mid;
  logic [ROW_W-1:0]           hv;
  logic signed [SAMPLE_W-1:0] h0, h1, h2;
  logic signed [PRED_W-1:0]   h0x, h1x, h2x, praw;
  logic signed [RES_W-1:0]    resid;
  logic [RES_W:0]             dbl;

  assign accept = in_valid_i && !in_stall_o;

  // Resolve channel count and frame position
  always_comb begin
    if (channel_count_i == '0) begin
      eff_n = N_W'(1);
    end else if ({1'b0, channel_count_i} > N_W'(MaxChannels)) begin
      eff_n = N_W'(MaxChannels);
    end else begin
      eff_n = {1'b0, channel_count_i};
    end
    pos_x    = N_W'(pos_q);
    pos_eff  = (pos_x >= eff_n) ? '0 : pos_x;
    pos_inc  = pos_eff + N_W'(1);
    pos_next = (pos_inc >= eff_n) ? '0 : pos_inc;
    stereo   = (eff_n == N_W'(2));
  end

  // Form side and mid with 16-bit wrap; floor halving of side
  assign side  = held_q - sample_i;
  assign half  = side >>> 1;
  assign mid   = sample_i + half;
  assign start = accept && !(stereo && (pos_eff == '0));

  // Unpack history row; rows never written read as zero
  assign hv  = rd_vld_q ? rd_row_q : '0;
  assign h0  = hv[SAMPLE_W-1:0];
  assign h1  = hv[2*SAMPLE_W-1:SAMPLE_W];
  assign h2  = hv[3*SAMPLE_W-1:2*SAMPLE_W];
  assign h0x = PRED_W'(h0);
  assign h1x = PRED_W'(h1);
  assign h2x = PRED_W'(h2);

  // Fixed polynomial prediction
  always_comb begin
    case (order_e'(predictor_order_i))
      ORD_ONE:   praw = h0x;
      ORD_TWO:   praw = (h0x <<< 1) - h1x;
      ORD_THREE: praw = (h0x <<< 1) + h0x - (h1x <<< 1) - h1x + h2x;
      default:   praw = '0;
    endcase
  end

  // Fold residual to unsigned
  assign resid = RES_W'(cur_smp_q) - RES_W'(pred_q);
  assign dbl   = {resid, 1'b0};

  assign job_o.mapped = dbl[RES_W] ? ~dbl[MAPPED_W-1:0] : dbl[MAPPED_W-1:0];
  assign job_o.ch     = CODED_CH_W'(cur_ch_q);
  assign job_o.last   = cur_last_q;

  // Datapath next values
  always_comb begin
    pos_d      = pos_q;
    held_d     = held_q;
    cur_ch_d   = cur_ch_q;
    cur_smp_d  = cur_smp_q;
    cur_last_d = cur_last_q;
    pend_d     = pend_q;
    pend_smp_d = pend_smp_q;
    pred_d     = pred_q;
    if (accept) begin
      if (stereo && (pos_eff == '0)) begin
        held_d = sample_i;
        pos_d  = CH_W'(1);
      end else if (stereo) begin
        pos_d      = '0;
        cur_ch_d   = '0;
        cur_smp_d  = mid;
        cur_last_d = 1'b0;
        pend_d     = 1'b1;
        pend_smp_d = side;
      end else begin
        pos_d      = pos_next[CH_W-1:0];
        cur_ch_d   = pos_eff[CH_W-1:0];
        cur_smp_d  = sample_i;
        cur_last_d = 1'b1;
        pend_d     = 1'b0;
      end
    end
    if (state_q == F_PRED) begin
      if (praw > PMAX) begin
        pred_d = SAMPLE_MAX;
      end else if (praw < PMIN) begin
        pred_d = SAMPLE_MIN;
      end else begin
        pred_d = praw[SAMPLE_W-1:0];
      end
    end
    // Advance to the side sample once mid is queued
    if (push_o && pend_q) begin
      cur_ch_d   = CH_W'(1);
      cur_smp_d  = pend_smp_q;
      cur_last_d = 1'b1;
      pend_d     = 1'b0;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      F_IDLE: if (start) state_d = F_READ;
      F_READ: state_d = F_PRED;
      F_PRED: state_d = F_PUSH;
      F_PUSH: begin
        if (!full_i) state_d = pend_q ? F_READ : F_IDLE;
      end
      default: state_d = F_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    in_stall_o = (state_q != F_IDLE);
    rd_en      = (state_q == F_READ);
    push_o     = (state_q == F_PUSH) && !full_i;
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= F_IDLE;
      pos_q     <= '0;
      held_q    <= '0;
      pend_q    <= 1'b0;
      row_vld_q <= '0;
    end else begin
      state_q <= state_d;
      pos_q   <= pos_d;
      held_q  <= held_d;
      pend_q  <= pend_d;
      if (push_o) row_vld_q[cur_ch_q] <= 1'b1;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    cur_ch_q   <= cur_ch_d;
    cur_smp_q  <= cur_smp_d;
    cur_last_q <= cur_last_d;
    pend_smp_q <= pend_smp_d;
    pred_q     <= pred_d;
  end

  // History memory: one row per channel, registered read
  always_ff @(posedge clk_i) begin
    if (push_o) hist_mem[cur_ch_q] <= {hv[ROW_W-SAMPLE_W-1:0], cur_smp_q};
    if (rd_en) rd_row_q <= hist_mem[cur_ch_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vld_q <= 1'b0;
    end else if (rd_en) begin
      rd_vld_q <= row_vld_q[cur_ch_q];
    end
  end

endmodule

>>> rtl/lagc_fifo.sv
// ----------------------------------------------------------------------------
// lagc_fifo
// Short first-word-fall-through queue of residual transactions.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module lagc_fifo import lagc_pkg::*; #(
  parameter int Depth = QUEUE_DEPTH
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t data_i,
  output logic full_o,
  input  logic pop_i,
  output job_t data_o,
  output logic empty_o
);

  localparam int PTR_W = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CNT_W = $clog2(Depth + 1);

  job_t             entries_q [Depth];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;

  assign full_o  = (count_q == CNT_W'(Depth));
  assign empty_o = (count_q == '0);
  assign data_o  = entries_q[rd_ptr_q];

  // Advance pointers and fill level
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(Depth - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(Depth - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (push_i && !pop_i) begin
      count_d = count_q + CNT_W'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store incoming transaction
  always_ff @(posedge clk_i) begin
    if (push_i) entries_q[wr_ptr_q] <= data_i;
  end

  `LAGC_ASSERT_NEVER(a_no_overflow, clk_i, rst_ni, push_i && full_o)
  `LAGC_ASSERT_NEVER(a_no_underflow, clk_i, rst_ni, pop_i && empty_o)

endmodule

>>> rtl/lagc_back.sv
// ----------------------------------------------------------------------------
// lagc_back
// Golomb coder: bit-serial division by m, quotient clamp and
// truncated-binary remainder, with a registered output stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module lagc_back import lagc_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [M_W-1:0]        golomb_m_i,
  input  logic                  empty_i,
  output logic                  pop_o,
  input  job_t                  job_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [ZRUN_W-1:0]     zero_run_o,
  output logic [SUFFIX_W-1:0]   suffix_bits_o,
  output logic [SLEN_W-1:0]     suffix_length_o,
  output logic [CODED_CH_W-1:0] coded_channel_o
  ,output logic                 last_of_run_o
);

  localparam int STEP_W = $clog2(MAPPED_W + 1);

  back_state_e state_q, state_d;

  logic [MAPPED_W-1:0]   dvd_q;
  logic [M_W-1:0]        rem_q;
  logic [STEP_W-1:0]     step_q;
  logic [M_W-1:0]        m_q;
  logic [SLEN_W-1:0]     b_q;
  logic [CODED_CH_W-1:0] ch_q;
  logic                  last_q;
  logic                  out_valid_q;

  logic [ZRUN_W-1:0]     zrun_q;
  logic [SUFFIX_W-1:0]   bits_q;
  logic [SLEN_W-1:0]     len_q;
  logic [CODED_CH_W-1:0] och_q;
  logic                  olast_q;

  logic [M_W-1:0]      m_eff, mm1;
  logic [M_W:0]        trial, diff, cutoff;
  logic                ge, lt, out_free, load_out, last_step;
  logic [ZRUN_W-1:0]   zrun_c;
  logic [SUFFIX_W-1:0] bits_c;
  logic [SLEN_W-1:0]   len_c;

  assign m_eff = (golomb_m_i == '0) ? M_W'(1) : golomb_m_i;
  assign mm1   = m_q - M_W'(1);

  // One restoring division step
  assign trial     = {rem_q, dvd_q[MAPPED_W-1]};
  assign diff      = trial - {1'b0, m_q};
  assign ge        = (trial >= {1'b0, m_q});
  assign last_step = (step_q == STEP_W'(MAPPED_W - 1));

  // Clamp quotient and build truncated-binary suffix
  always_comb begin
    if (dvd_q > MAPPED_W'(QUOTIENT_CAP)) begin
      zrun_c = QUOTIENT_CAP;
    end else begin
      zrun_c = dvd_q[ZRUN_W-1:0];
    end
    cutoff = ((M_W + 1)'(1) << b_q) - {1'b0, m_q};
    lt     = ({1'b0, rem_q} < cutoff);
    if (lt) begin
      len_c  = (b_q > SLEN_W'(1)) ? b_q - SLEN_W'(1) : '0;
      bits_c = rem_q;
    end else begin
      len_c  = b_q;
      bits_c = rem_q + cutoff[SUFFIX_W-1:0];
    end
    if (len_c == '0) bits_c = '0;
  end

  assign out_free = !out_valid_q || !out_stall_i;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      B_IDLE: if (!empty_i) state_d = B_DIV;
      B_DIV:  if (last_step) state_d = B_DONE;
      B_DONE: if (out_free) state_d = B_IDLE;
      default: state_d = B_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    pop_o    = (state_q == B_IDLE) && !empty_i;
    load_out = (state_q == B_DONE) && out_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (pop_o) begin
        step_q <= '0;
      end else if (state_q == B_DIV) begin
        step_q <= step_q + STEP_W'(1);
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Load job, then shift one quotient bit per cycle; track bit length of m-1
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      dvd_q  <= job_i.mapped;
      rem_q  <= '0;
      m_q    <= m_eff;
      b_q    <= '0;
      ch_q   <= job_i.ch;
      last_q <= job_i.last;
    end else if (state_q == B_DIV) begin
      dvd_q <= {dvd_q[MAPPED_W-2:0], ge};
      rem_q <= ge ? diff[M_W-1:0] : trial[M_W-1:0];
      if ((step_q < STEP_W'(M_W)) && mm1[step_q[$clog2(M_W)-1:0]]) begin
        b_q <= SLEN_W'(step_q) + SLEN_W'(1);
      end
    end
  end

  // Output register
  always_ff @(posedge clk_i) begin
    if (load_out) begin
      zrun_q  <= zrun_c;
      bits_q  <= bits_c;
      len_q   <= len_c;
      och_q   <= ch_q;
      olast_q <= last_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign zero_run_o      = zrun_q;
  assign suffix_bits_o   = bits_q;
  assign suffix_length_o = len_q;
  assign coded_channel_o = och_q;
  assign last_of_run_o   = olast_q;

  `LAGC_ASSERT_IMPLIES(a_zrun_capped, clk_i, rst_ni, out_valid_q, zrun_q <= QUOTIENT_CAP)
  `LAGC_ASSERT_IMPLIES(a_len_bound, clk_i, rst_ni, out_valid_q, len_q <= SLEN_W'(M_W))

endmodule

>>> rtl/lossless_audio_golomb_encoder.sv
// ----------------------------------------------------------------------------
// lossless_audio_golomb_encoder: fixed-predictor Golomb residual coder
// Code words are formed one at a time by the 17-step serial divider.
// Reset: config to defaults, histories read as zero, no clearing pass.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lossless_audio_golomb_encoder import lagc_pkg::*; #(
  parameter int MaxChannels = MAX_CHANNELS,
  parameter int QueueDepth  = QUEUE_DEPTH
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]      cfg_wdata_i,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic signed [SAMPLE_W-1:0] sample_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [ZRUN_W-1:0]          zero_run_o,
  output logic [SUFFIX_W-1:0]        suffix_bits_o,
  output logic [SLEN_W-1:0]          suffix_length_o,
  output logic [CODED_CH_W-1:0]      coded_channel_o,
  output logic                       last_of_run_o
);

  logic [ORDER_W-1:0] order_q, order_d;
  logic [M_W-1:0]     m_q, m_d;
  logic [COUNT_W-1:0] count_q, count_d;

  logic push, full, pop, empty;
  job_t job_in, job_out;

  // Decode configuration writes
  always_comb begin
    order_d = order_q;
    m_d     = m_q;
    count_d = count_q;
    if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_ORDER:    order_d = cfg_wdata_i[ORDER_W-1:0];
        CFG_GOLOMB_M: m_d     = cfg_wdata_i[M_W-1:0];
        CFG_CHANNELS: count_d = cfg_wdata_i[COUNT_W-1:0];
        default:      ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      order_q <= ORDER_RST;
      m_q     <= M_RST;
      count_q <= COUNT_RST;
    end else begin
      order_q <= order_d;
      m_q     <= m_d;
      count_q <= count_d;
    end
  end

  lagc_front #(
    .MaxChannels(MaxChannels)
  ) u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .predictor_order_i(order_q),
    .channel_count_i  (count_q),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .sample_i         (sample_i),
    .push_o           (push),
    .job_o            (job_in),
    .full_i           (full)
  );

  lagc_fifo #(
    .Depth(QueueDepth)
  ) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (job_in),
    .full_o (full),
    .pop_i  (pop),
    .data_o (job_out),
    .empty_o(empty)
  );

  lagc_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .golomb_m_i     (m_q),
    .empty_i        (empty),
    .pop_o          (pop),
    .job_i          (job_out),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .zero_run_o     (zero_run_o),
    .suffix_bits_o  (suffix_bits_o),
    .suffix_length_o(suffix_length_o),
    .coded_channel_o(coded_channel_o),
    .last_of_run_o  (last_of_run_o)
  );

endmodule

>>> sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: lossless audio Golomb encoder
// Drives interleaved PCM samples and register settings into the encoder,
// tracks the predictor, mid/side and Golomb coding in a local model, and
// compares every code word against the oldest outstanding prediction.
// ----------------------------------------------------------------------------

module testbench;
  import lagc_pkg::*;

  // One predicted or observed code word
  typedef struct packed {
    logic [ZRUN_W-1:0]     zero_run;
    logic [SUFFIX_W-1:0]   suffix_bits;
    logic [SLEN_W-1:0]     suffix_length;
    logic [CODED_CH_W-1:0] coded_channel;
    logic                  last_of_run;
  } code_word_t;

  // DUT signals; the inputs are all known from time zero
  logic                       clk_i       = 1'b0;
  logic                       rst_ni      = 1'b0;
  logic                       cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0]       cfg_idx_i   = '0;
  logic [CFG_DATA_W-1:0]      cfg_wdata_i = '0;
  logic                       in_valid_i  = 1'b0;
  logic                       in_stall_o;
  logic signed [SAMPLE_W-1:0] sample_i    = '0;
  logic                       out_valid_o;
  logic                       out_stall_i = 1'b0;
  logic [ZRUN_W-1:0]          zero_run_o;
  logic [SUFFIX_W-1:0]        suffix_bits_o;
  logic [SLEN_W-1:0]          suffix_length_o;
  logic [CODED_CH_W-1:0]      coded_channel_o;
  logic                       last_of_run_o;

  // Code words predicted and not yet seen
  code_word_t pending_codes[$];

  // Local copy of encoder state and registers
  logic signed [SAMPLE_W-1:0] chan_hist [MAX_CHANNELS][HISTORY_TAPS] = '{default: '0};
  logic signed [SAMPLE_W-1:0] left_hold  = '0;
  int                         frame_pos  = 0;
  logic [ORDER_W-1:0]         order_reg  = ORDER_RST;
  logic [M_W-1:0]             divisor_reg = M_RST;
  logic [COUNT_W-1:0]         chans_reg  = COUNT_RST;

  // Last drawn sample per channel slot, for smooth waveforms
  logic signed [SAMPLE_W-1:0] wave [MAX_CHANNELS] = '{default: '0};

  // Idling controls
  bit tx_idle_on  = 1'b1;
  bit rx_idle_on  = 1'b1;
  int rx_hold_req = 0;

  int error_count = 0;

  lossless_audio_golomb_encoder uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .sample_i        (sample_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .zero_run_o      (zero_run_o),
    .suffix_bits_o   (suffix_bits_o),
    .suffix_length_o (suffix_length_o),
    .coded_channel_o (coded_channel_o),
    .last_of_run_o   (last_of_run_o)
  );

  // Clock: 4 ns period
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Run limit, far beyond the slowest correct run
  initial begin
    #4000000;
    $display("testbench: done, errors");
    $finish;
  end

  // Print one mismatch line and count it; keep the log bounded
  task automatic report_mismatch(input string msg);
    error_count++;
    if (error_count <= 100) $display("mismatch at %0t: %s", $realtime, msg);
  endtask

  // Predict one code word for a coded channel and advance its history
  task automatic encode_residual(input int ch, input logic signed [SAMPLE_W-1:0] s,
                                 input bit last);
    int h0, h1, h2, pred, resid, mapped, mdiv, q, r, b, cutoff, bits, len;
    code_word_t w;
    h0 = chan_hist[ch][0];
    h1 = chan_hist[ch][1];
    h2 = chan_hist[ch][2];
    case (order_e'(order_reg))
      ORD_ONE:   pred = h0;
      ORD_TWO:   pred = 2 * h0 - h1;
      ORD_THREE: pred = 3 * h0 - 3 * h1 + h2;
      default:   pred = 0;
    endcase
    if (pred > int'(SAMPLE_MAX)) pred = int'(SAMPLE_MAX);
    if (pred < int'(SAMPLE_MIN)) pred = int'(SAMPLE_MIN);

    // Fold the residual to unsigned
    resid  = int'(s) - pred;
    mapped = (resid >= 0) ? 2 * resid : -2 * resid - 1;

    chan_hist[ch][2] = chan_hist[ch][1];
    chan_hist[ch][1] = chan_hist[ch][0];
    chan_hist[ch][0] = s;

    // Divisor zero behaves as one
    mdiv = (divisor_reg == '0) ? 1 : int'(divisor_reg);
    q = mapped / mdiv;
    r = mapped % mdiv;
    if (q > int'(QUOTIENT_CAP)) q = int'(QUOTIENT_CAP);

    // Truncated-binary remainder
    b = 0;
    while (b < 16 && (1 << b) < mdiv) b++;
    cutoff = (1 << b) - mdiv;
    if (r < cutoff) begin
      bits = r;
      len  = (b > 1) ? b - 1 : 0;
    end else begin
      bits = r + cutoff;
      len  = b;
    end
    if (len == 0) bits = 0;

    w.zero_run      = q[ZRUN_W-1:0];
    w.suffix_bits   = bits[SUFFIX_W-1:0];
    w.suffix_length = len[SLEN_W-1:0];
    w.coded_channel = ch[CODED_CH_W-1:0];
    w.last_of_run   = last;
    pending_codes = {pending_codes, w};
  endtask

  // Track one accepted sample through channel position and mid/side logic
  task automatic track_sample(input logic signed [SAMPLE_W-1:0] s);
    int n, pos;
    logic signed [SAMPLE_W-1:0] side, mid;
    n = (chans_reg == '0) ? 1 : (chans_reg > MAX_CHANNELS) ? MAX_CHANNELS : int'(chans_reg);
    pos = frame_pos;
    // A position left over from a wider setting restarts the frame
    if (pos >= n) pos = 0;
    if (n == 2) begin
      if (pos == 0) begin
        left_hold = s;
        frame_pos = 1;
      end else begin
        side = 16'(int'(left_hold) - int'(s));
        mid  = 16'(int'(s) + int'(side >>> 1));
        frame_pos = 0;
        encode_residual(0, mid, 1'b0);
        encode_residual(1, side, 1'b1);
      end
    end else begin
      encode_residual(pos, s, 1'b1);
      frame_pos = (pos + 1 >= n) ? 0 : pos + 1;
    end
  endtask

  // Offer one sample, hold it until the transaction, then predict
  task automatic send_sample(input logic signed [SAMPLE_W-1:0] s);
    bit taken;
    if (tx_idle_on && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    sample_i   <= s;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk_i);
      taken = !in_stall_o;
      @(posedge clk_i);
    end
    track_sample(s);
  endtask

  // Pause input until every predicted code word has arrived, then let it settle
  task automatic drain_outputs();
    in_valid_i <= 1'b0;
    while (pending_codes.size() != 0) @(posedge clk_i);
    repeat (48) @(posedge clk_i);
  endtask

  // Write one register through the config port
  task automatic write_reg(input cfg_idx_e idx, input logic [CFG_DATA_W-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    case (idx)
      CFG_ORDER:    order_reg   = value[ORDER_W-1:0];
      CFG_GOLOMB_M: divisor_reg = value[M_W-1:0];
      CFG_CHANNELS: chans_reg   = value[COUNT_W-1:0];
      default: ;
    endcase
  endtask

  // Bring the encoder idle and load all three registers
  task automatic apply_setting(input order_e order, input logic [M_W-1:0] m,
                               input logic [COUNT_W-1:0] chans);
    drain_outputs();
    write_reg(CFG_ORDER, CFG_DATA_W'(order));
    write_reg(CFG_GOLOMB_M, CFG_DATA_W'(m));
    write_reg(CFG_CHANNELS, CFG_DATA_W'(chans));
  endtask

  // Draw a sample: mostly smooth per channel, some noise and extremes
  function automatic logic signed [SAMPLE_W-1:0] draw_sample();
    int pick, k, step, slot;
    logic signed [SAMPLE_W-1:0] s;
    slot = frame_pos % MAX_CHANNELS;
    pick = $urandom_range(0, 9);
    if (pick < 6) begin
      k    = $urandom_range(0, 10);
      step = int'($urandom_range(0, 2 * (1 << k))) - (1 << k);
      s    = 16'(int'(wave[slot]) + step);
    end else if (pick < 8) begin
      s = 16'($urandom);
    end else if (pick == 8) begin
      case ($urandom_range(0, 3))
        0:       s = SAMPLE_MAX;
        1:       s = SAMPLE_MIN;
        2:       s = '0;
        default: s = -16'sd1;
      endcase
    end else begin
      s = 16'(int'($urandom_range(0, 64)) - 32);
    end
    wave[slot] = s;
    return s;
  endfunction

  // Stereo with reset settings: held left, side and mid wrap, quotient cap
  task automatic test_stereo_defaults();
    send_sample(SAMPLE_MAX);
    send_sample(SAMPLE_MIN);
    send_sample(SAMPLE_MIN);
    send_sample(SAMPLE_MAX);
    send_sample(16'sd0);
    send_sample(16'sd0);
    send_sample(SAMPLE_MAX);
    send_sample(SAMPLE_MAX);
  endtask

  // Mono through orders three, two and one, prediction clamp, divisor extremes
  task automatic test_predictor_orders();
    apply_setting(ORD_THREE, 16'd0, 4'd1);
    send_sample(SAMPLE_MAX);
    send_sample(SAMPLE_MIN);
    send_sample(SAMPLE_MAX);
    send_sample(SAMPLE_MIN);
    apply_setting(ORD_TWO, 16'hFFFF, 4'd1);
    send_sample(16'sd0);
    send_sample(SAMPLE_MAX);
    apply_setting(ORD_ONE, 16'd3, 4'd1);
    send_sample(SAMPLE_MIN);
    send_sample(16'sd12345);
  endtask

  // Channel counts: shrink below the frame position, zero, above the maximum
  task automatic test_channel_counts();
    apply_setting(ORD_ONE, 16'd2, 4'd5);
    send_sample(16'sd100);
    send_sample(-16'sd200);
    send_sample(16'sd300);
    apply_setting(ORD_ONE, 16'd2, 4'd3);
    send_sample(16'sd400);
    send_sample(-16'sd500);
    apply_setting(ORD_NONE, 16'd5, 4'd0);
    send_sample(-16'sd1);
    apply_setting(ORD_TWO, 16'd7, 4'd15);
    send_sample(16'sd1);
    send_sample(16'sd2);
    apply_setting(ORD_ONE, 16'd9, 4'd9);
    send_sample(16'sd3);
  endtask

  // Long receiver hold while samples keep coming, then drain fully
  task automatic test_backpressure();
    apply_setting(ORD_TWO, 16'd4, 4'd2);
    tx_idle_on  = 1'b0;
    rx_idle_on  = 1'b0;
    rx_hold_req = 300;
    repeat (24) send_sample(draw_sample());
    drain_outputs();
    apply_setting(ORD_ONE, 16'd6, 4'd3);
    rx_hold_req = 200;
    repeat (12) send_sample(draw_sample());
    drain_outputs();
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
  endtask

  // Random phases, each with its own register setting; last phases run flat out
  task automatic test_random_phases();
    order_e     order;
    logic [M_W-1:0] m;
    logic [COUNT_W-1:0] chans;
    for (int phase = 0; phase < 12; phase++) begin
      order = order_e'($urandom_range(0, 3));
      case ($urandom_range(0, 7))
        0:       m = 16'd0;
        1:       m = 16'd1;
        2:       m = 16'hFFFF;
        3:       m = 16'($urandom);
        4, 5:    m = 16'($urandom_range(2, 16));
        default: m = 16'($urandom_range(17, 600));
      endcase
      case ($urandom_range(0, 5))
        0, 1:    chans = 4'd2;
        2:       chans = 4'd1;
        3:       chans = 4'($urandom_range(0, 15));
        default: chans = 4'($urandom_range(3, 8));
      endcase
      // Pin the extremes in the first phases
      case (phase)
        0: begin order = ORD_THREE; m = 16'd1;    chans = 4'd2;  end
        1: begin order = ORD_NONE;  m = 16'hFFFF; chans = 4'd8;  end
        2: begin order = ORD_TWO;   m = 16'd0;    chans = 4'd15; end
        default: ;
      endcase
      apply_setting(order, m, chans);
      tx_idle_on = (phase < 10);
      rx_idle_on = (phase < 10);
      repeat (68) send_sample(draw_sample());
    end
  endtask

  // Receiver: random stall bursts, or a long hold when requested
  initial begin : receiver
    int n;
    forever begin
      @(posedge clk_i);
      if (rx_hold_req > 0) begin
        n = rx_hold_req;
        rx_hold_req = 0;
        out_stall_i <= 1'b1;
        repeat (n) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end else if (rx_idle_on && $urandom_range(0, 7) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  // Compare each code word transaction with the oldest prediction
  initial begin : code_checker
    code_word_t got, want;
    forever begin
      @(negedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) begin
        got = {zero_run_o, suffix_bits_o, suffix_length_o, coded_channel_o, last_of_run_o};
        if (pending_codes.size() == 0) begin
          report_mismatch($sformatf("unexpected code word zr=%0d bits=%h len=%0d ch=%0d last=%0d",
                                    got.zero_run, got.suffix_bits, got.suffix_length,
                                    got.coded_channel, got.last_of_run));
        end else begin
          want = pending_codes.pop_front();
          if (got !== want) begin
            report_mismatch($sformatf(
              "got zr=%0d bits=%h len=%0d ch=%0d last=%0d, want zr=%0d bits=%h len=%0d ch=%0d last=%0d",
              got.zero_run, got.suffix_bits, got.suffix_length, got.coded_channel,
              got.last_of_run, want.zero_run, want.suffix_bits, want.suffix_length,
              want.coded_channel, want.last_of_run));
          end
        end
      end
    end
  end

  // Sequence: reset, directed tests, random phases, final verdict
  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_stereo_defaults();
    test_predictor_orders();
    test_channel_counts();
    test_backpressure();
    test_random_phases();
    drain_outputs();
    if (error_count == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
